/* rtl/binary_to_decimal_ascii_defines.svh */
// Assertion macros used by the b2d checker.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define B2D_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("b2d assertion failed");

// Check that a condition implies another in the same cycle.
`define B2D_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("b2d assertion failed");

// Check that a condition implies another in the next cycle.
`define B2D_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("b2d assertion failed");

`endif

/* rtl/b2d_pkg.sv */
package b2d_pkg;

  // Ceiling on the character count of one number
  localparam int MAX_CHARS  = 16;
  // A 31-bit value has at most ten decimal digits
  localparam int MAX_DIGITS = 10;

  // Field widths
  localparam int VALUE_W = 31;
  localparam int MINC_W  = 5;
  localparam int CHAR_W  = 8;
  localparam int TOTAL_W = 5;

  // Internal widths
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);
  localparam int DIG_CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int DIG_IDX_W = $clog2(MAX_DIGITS);
  localparam int BCD_W     = 4 * MAX_DIGITS;
  // Shift register width: value plus a zero bit, two bits per step
  localparam int BIN_W     = VALUE_W + 1;
  localparam int STEPS     = BIN_W / 2;
  localparam int STEP_W    = $clog2(STEPS);

  // Queue between converter and emitter
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Characters
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // Converted number waiting to be spelled out
  typedef struct packed {
    logic [MAX_DIGITS-1:0][3:0] digits;
    logic [CNT_W-1:0]           total;
    logic [CNT_W-1:0]           npad;
    logic                       pad_zero;
  } b2d_desc_t;

endpackage

/* rtl/b2d_if.sv */
// Input channel: one number with its formatting request
interface b2d_in_if
  import b2d_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               func;
  logic [VALUE_W-1:0] value;
  logic [MINC_W-1:0]  min_chars;

  modport source (output valid, func, value, min_chars, input ready);
  modport sink   (input valid, func, value, min_chars, output ready);
  modport monitor (input valid, ready, func, value, min_chars);
endinterface

// Output channel: one character of the decimal text
interface b2d_out_if
  import b2d_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  ascii_char;
  logic [TOTAL_W-1:0] total_chars;
  logic               last;

  modport source (output valid, ascii_char, total_chars, last, input ready);
  modport sink   (input valid, ascii_char, total_chars, last, output ready);
  modport monitor (input valid, ready, ascii_char, total_chars, last);
endinterface

/* rtl/b2d_front.sv */
module b2d_front
  import b2d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  b2d_in_if.sink     in_i,
  output logic       push_o,
  output b2d_desc_t  desc_o,
  input  logic       full_i
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } state_e;

  state_e            state_q;
  logic [BIN_W-1:0]  bin_q;
  logic [BCD_W-1:0]  bcd_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  min_q;
  logic              pad_zero_q;

  logic [BCD_W-1:0]      bcd_d;
  logic [CNT_W-1:0]      min_sat;
  logic [DIG_CNT_W-1:0]  ndig;
  logic [CNT_W-1:0]      total;

  // One double-dabble step: adjust digits of five or more, shift in a bit
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd, input logic b);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction

  // Two bits per cycle
  assign bcd_d = dabble(dabble(bcd_q, bin_q[BIN_W-1]), bin_q[BIN_W-2]);

  // Saturate the minimum count
  always_comb begin
    if (int'(in_i.min_chars) > MAX_CHARS) begin
      min_sat = CNT_W'(MAX_CHARS);
    end else begin
      min_sat = CNT_W'(in_i.min_chars);
    end
  end

  // Count digits up to the highest nonzero one; zero keeps one digit
  always_comb begin
    ndig = DIG_CNT_W'(1);
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        ndig = DIG_CNT_W'(i + 1);
      end
    end
    total = (min_q > CNT_W'(ndig)) ? min_q : CNT_W'(ndig);
  end

  assign in_i.ready = (state_q == F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !full_i;

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      desc_o.digits[i] = bcd_q[4*i +: 4];
    end
    desc_o.total    = total;
    desc_o.npad     = total - CNT_W'(ndig);
    desc_o.pad_zero = pad_zero_q;
  end

  // Accept, convert, hand over to the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_i.valid) begin
            state_q <= F_CONV;
            step_q  <= '0;
          end
        end
        F_CONV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(STEPS - 1)) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_i.valid) begin
      bin_q      <= {1'b0, in_i.value};
      bcd_q      <= '0;
      min_q      <= min_sat;
      pad_zero_q <= in_i.func;
    end else if (state_q == F_CONV) begin
      bin_q <= {bin_q[BIN_W-3:0], 2'b00};
      bcd_q <= bcd_d;
    end
  end

endmodule

/* rtl/b2d_fifo.sv */
module b2d_fifo
  import b2d_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  b2d_desc_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output b2d_desc_t data_o
);

  b2d_desc_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q;
  logic [FIFO_PTR_W-1:0] rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;

  assign full_o  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FIFO_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + FIFO_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - FIFO_CNT_W'(1);
      end
    end
  end

  // Store an entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/b2d_back.sv */
module b2d_back
  import b2d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  b2d_desc_t  desc_i,
  output logic       pop_o,
  b2d_out_if.source  out_o
);

  logic [CNT_W-1:0]   k_q;
  logic               out_valid_q;
  logic [CHAR_W-1:0]  char_q;
  logic [TOTAL_W-1:0] total_q;
  logic               last_q;

  logic               adv;
  logic               is_last;
  logic [CNT_W-1:0]   pos;
  logic [CHAR_W-1:0]  char_d;

  // Load the output register when it is empty or being drained
  assign adv     = valid_i && (!out_valid_q || out_o.ready);
  assign is_last = (k_q == desc_i.total - CNT_W'(1));
  assign pop_o   = adv && is_last;
  assign pos     = desc_i.total - CNT_W'(1) - k_q;

  // Pad first, then digits from the most significant one
  always_comb begin
    if (k_q < desc_i.npad) begin
      char_d = desc_i.pad_zero ? CHAR_ZERO : CHAR_SPACE;
    end else begin
      char_d = CHAR_ZERO + {4'd0, desc_i.digits[pos[DIG_IDX_W-1:0]]};
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.ascii_char  = char_q;
  assign out_o.total_chars = total_q;
  assign out_o.last        = last_q;

  // Advance the character counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
        k_q         <= is_last ? '0 : k_q + CNT_W'(1);
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the character until taken
  always_ff @(posedge clk_i) begin
    if (adv) begin
      char_q  <= char_d;
      total_q <= TOTAL_W'(desc_i.total);
      last_q  <= is_last;
    end
  end

endmodule

/* rtl/binary_to_decimal_ascii.sv */
// Channel  Dir  Fields                               Handshake
// in_i     in   func, value[30:0], min_chars[4:0]    valid / ready
// out_o    out  ascii_char[7:0], total_chars[4:0],   valid / ready
//               last
//
// The converter takes one number at a time: an accept state, 16
// double-dabble steps at two bits a cycle, then a push state that writes
// the two-entry queue and waits while the queue is full.
// The emitter sends one character a cycle while the queue holds a number
// and the output is ready, so it can spell one number while the next converts.
// Reset is asynchronous and clears the FSM, queue pointers and output valid.
// A stalled output holds its register; the queue lets conversion run ahead.
module binary_to_decimal_ascii
  import b2d_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  b2d_in_if.sink    in_i,
  b2d_out_if.source out_o
);

  logic      push;
  logic      full;
  logic      pop;
  logic      q_valid;
  b2d_desc_t push_desc;
  b2d_desc_t head_desc;

  b2d_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .desc_o (push_desc),
    .full_i (full)
  );

  b2d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_desc),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (head_desc)
  );

  b2d_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .desc_i  (head_desc),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

/* rtl/b2d_checker.sv */
`include "binary_to_decimal_ascii_defines.svh"

module b2d_checker
  import b2d_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [CHAR_W-1:0]  out_char_i,
  input logic [TOTAL_W-1:0] out_total_i,
  input logic               out_last_i
);

  logic                     out_take;
  logic                     out_stall;
  logic                     mid_take;
  logic                     in_take;
  logic                     char_ok;
  logic                     single_char;
  logic [CHAR_W+TOTAL_W:0]  out_word;

  assign out_take    = out_valid_i && out_ready_i;
  assign out_stall   = out_valid_i && !out_ready_i;
  assign mid_take    = out_take && !out_last_i;
  assign in_take     = in_valid_i && in_ready_i;
  assign out_word    = {out_char_i, out_total_i, out_last_i};
  assign single_char = out_valid_i && (out_total_i == TOTAL_W'(1));
  assign char_ok     = (out_char_i == CHAR_SPACE) ||
                       (out_char_i >= CHAR_ZERO && out_char_i <= CHAR_NINE);

  // A stalled character holds
  `B2D_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_word))

  // Only spaces and decimal digits appear
  `B2D_ASSERT_IMP(a_char_set, clk_i, rst_ni, out_valid_i, char_ok)

  // Within one number the length stays put
  `B2D_ASSERT_NXT(a_total_same, clk_i, rst_ni, mid_take, !out_valid_i || $stable(out_total_i))

  // A one-character text ends at once
  `B2D_ASSERT_IMP(a_single_last, clk_i, rst_ni, single_char, out_last_i)

  // The converter does not take two numbers in a row
  `B2D_ASSERT_NXT(a_in_spacing, clk_i, rst_ni, in_take, !in_ready_i)

endmodule

bind binary_to_decimal_ascii b2d_checker u_b2d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.ascii_char),
  .out_total_i (out_o.total_chars),
  .out_last_i  (out_o.last)
);
